### src/gsip_pkg.sv
// Shared constants, types and register indexes of the gain-scheduled incremental PID block.
package gsip_pkg;

   // Schedule size and gain format
   localparam int GAIN_ROWS      = 4;
   localparam int GAIN_FRAC_BITS = 6;
   localparam int ROW_REGS       = 4;
   localparam int SEL_ROWS       = (GAIN_ROWS < ROW_REGS) ? GAIN_ROWS : ROW_REGS;
   localparam int ROW_IDX_W      = $clog2(ROW_REGS);

   // Field widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int SPEED_W    = 16;
   localparam int ERR_W      = SPEED_W + 1;
   localparam int GAIN_W     = 16;
   localparam int DRIVE_W    = 16;
   localparam int ACC_W      = 40;

   // Register indexes above the gain rows
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DRIVE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DRIVE = 3'd5;

   // Reset values of the drive clamps
   localparam logic [DRIVE_W-1:0] MIN_DRIVE_RST = 16'd5000;
   localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST = 16'hFFFF;

   typedef logic [CSR_DATA_W-1:0] gain_row_type;

   // Gains picked for one item, plus whether any row matched
   typedef struct packed {
      logic              found;
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gain_sel_type;

endpackage

### src/gsip_row_select.sv
// Gain schedule lookup: first row whose threshold exceeds the error magnitude.
module gsip_row_select (
   input  gsip_pkg::gain_row_type gain_rows [gsip_pkg::ROW_REGS],
   input  logic [gsip_pkg::ERR_W-1:0] err_mag,
   output gsip_pkg::gain_sel_type     sel
);
   import gsip_pkg::*;

   // Walk from the last row down so the lowest matching row wins
   always_comb begin
      sel = '0;
      for (int i = SEL_ROWS - 1; i >= 0; i--) begin
         if ({1'b0, gain_rows[i][15:0]} > err_mag) begin
            sel.found = 1'b1;
            sel.kp    = gain_rows[i][31:16];
            sel.ki    = gain_rows[i][47:32];
            sel.kd    = gain_rows[i][63:48];
         end
      end
   end

endmodule

### src/gain_scheduled_incremental_pid.sv
// Top level of the gain-scheduled incremental (velocity-form) PID speed loop.
//
// Each transfer on the req_ channel carries a target and a measured speed; one
// result per item comes out on the rsp_ channel, in order. The block is a
// two-register pipe: the input register holds the error and the gains chosen
// from the schedule, and the result register holds the new drive. One item is
// taken every clock cycle while rsp_ready does not stall the result register.
// The input register loads on the transfer, and the result register loads from
// it once it is free or being taken, which raises rsp_valid; the result is then
// taken while rsp_ready is high. The loop state (error history and
// accumulated drive) updates in the same edge that loads the result register,
// so consecutive items see each other's state without extra stalls. A result
// with rsp_no_gain_row set repeats the drive and leaves the state as it was.
// Write the gain rows and the drive clamps on the csr_ port while the block is
// idle; they reset to zero rows, a lower clamp of 5000 and an upper of 65535.
module gain_scheduled_incremental_pid (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration writes
   input  logic                                 csr_we,
   input  logic [gsip_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gsip_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // Input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [gsip_pkg::SPEED_W-1:0]  req_target_speed,
   input  logic signed [gsip_pkg::SPEED_W-1:0]  req_measured_speed,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gsip_pkg::DRIVE_W-1:0]         rsp_drive_level,
   output logic                                 rsp_no_gain_row
);
   import gsip_pkg::*;

   localparam logic signed [ACC_W-1:0] FRAC_BIAS =
      ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

   // Configuration registers
   gain_row_type        gain_row_ff [ROW_REGS];
   gain_row_type        gain_row_in [ROW_REGS];
   logic [DRIVE_W-1:0]  min_drive_ff, min_drive_in;
   logic [DRIVE_W-1:0]  max_drive_ff, max_drive_in;

   // Input stage
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [ERR_W-1:0] s1_err_ff, s1_err_in;
   gain_sel_type            s1_sel_ff, s1_sel_in;

   // Loop state
   logic signed [ERR_W-1:0] last_err_ff, last_err_in;
   logic signed [ERR_W-1:0] older_err_ff, older_err_in;
   logic [DRIVE_W-1:0]      drive_ff, drive_in;

   // Result stage
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]      rsp_drive_ff, rsp_drive_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic req_xfer;
   logic s2_load;

   // Input-side error and lookup
   logic [ERR_W-1:0]        tgt_ext, meas_ext, abs_tgt, abs_meas, err_mag;
   logic signed [ERR_W-1:0] err_now;
   gain_sel_type            sel_now;

   // Increment datapath
   logic signed [ERR_W:0]   d_prop;
   logic signed [ERR_W+1:0] d_deriv;
   logic signed [34:0]      prod_p;
   logic signed [33:0]      prod_i;
   logic signed [35:0]      prod_d;
   logic signed [ACC_W-1:0] acc, acc_scaled, sum, min_s, max_s;
   logic [DRIVE_W-1:0]      drive_next;

   // Handshake: the input register advances whenever the result register frees
   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign req_xfer  = req_valid && req_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_level = rsp_drive_ff;
   assign rsp_no_gain_row = rsp_flag_ff;

   // Speed magnitudes and signed error
   always_comb begin
      tgt_ext  = {req_target_speed[SPEED_W-1], req_target_speed};
      meas_ext = {req_measured_speed[SPEED_W-1], req_measured_speed};
      abs_tgt  = req_target_speed[SPEED_W-1] ? (ERR_W'(0) - tgt_ext) : tgt_ext;
      abs_meas = req_measured_speed[SPEED_W-1] ? (ERR_W'(0) - meas_ext) : meas_ext;
      err_now  = $signed(abs_tgt - abs_meas);
      err_mag  = err_now[ERR_W-1] ? (ERR_W'(0) - err_now) : err_now;
   end

   gsip_row_select u_row_select (
      .gain_rows (gain_row_ff),
      .err_mag   (err_mag),
      .sel       (sel_now)
   );

   // Velocity-form increment, truncated toward zero, then clamped
   always_comb begin
      d_prop  = {s1_err_ff[ERR_W-1], s1_err_ff} - {last_err_ff[ERR_W-1], last_err_ff};
      d_deriv = {{2{s1_err_ff[ERR_W-1]}}, s1_err_ff}
              - {last_err_ff[ERR_W-1], last_err_ff, 1'b0}
              + {{2{older_err_ff[ERR_W-1]}}, older_err_ff};
      prod_p  = $signed({1'b0, s1_sel_ff.kp}) * d_prop;
      prod_i  = $signed({1'b0, s1_sel_ff.ki}) * s1_err_ff;
      prod_d  = $signed({1'b0, s1_sel_ff.kd}) * d_deriv;
      acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
      acc_scaled = acc[ACC_W-1] ? ((acc + FRAC_BIAS) >>> GAIN_FRAC_BITS)
                                : (acc >>> GAIN_FRAC_BITS);
      sum   = acc_scaled + ACC_W'($signed({1'b0, drive_ff}));
      min_s = ACC_W'($signed({1'b0, min_drive_ff}));
      max_s = ACC_W'($signed({1'b0, max_drive_ff}));
      priority if (sum > max_s) begin
         drive_next = max_drive_ff;
      end else if (sum < min_s) begin
         drive_next = min_drive_ff;
      end else begin
         drive_next = sum[DRIVE_W-1:0];
      end
   end

   // Next values of all registers
   always_comb begin
      gain_row_in  = gain_row_ff;
      min_drive_in = min_drive_ff;
      max_drive_in = max_drive_ff;
      s1_valid_in  = s1_valid_ff;
      s1_err_in    = s1_err_ff;
      s1_sel_in    = s1_sel_ff;
      last_err_in  = last_err_ff;
      older_err_in = older_err_ff;
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_flag_in  = rsp_flag_ff;

      // Write configuration; unknown indexes drop
      if (csr_we) begin
         if (csr_index < CSR_IDX_W'(ROW_REGS)) begin
            gain_row_in[csr_index[ROW_IDX_W-1:0]] = csr_wdata;
         end else if (csr_index == CSR_MIN_DRIVE) begin
            min_drive_in = csr_wdata[DRIVE_W-1:0];
         end else if (csr_index == CSR_MAX_DRIVE) begin
            max_drive_in = csr_wdata[DRIVE_W-1:0];
         end
      end

      // Advance the input register
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_err_in   = err_now;
         s1_sel_in   = sel_now;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end

      // Load the result and update the loop state; hold it when no row matched
      if (s2_load) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in  = !s1_sel_ff.found;
         if (s1_sel_ff.found) begin
            drive_in     = drive_next;
            last_err_in  = s1_err_ff;
            older_err_in = last_err_ff;
            rsp_drive_in = drive_next;
         end else begin
            rsp_drive_in = drive_ff;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_REGS; i++) begin
            gain_row_ff[i] <= '0;
         end
         min_drive_ff <= MIN_DRIVE_RST;
         max_drive_ff <= MAX_DRIVE_RST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         older_err_ff <= '0;
         drive_ff     <= '0;
      end else begin
         gain_row_ff  <= gain_row_in;
         min_drive_ff <= min_drive_in;
         max_drive_ff <= max_drive_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_err_ff  <= last_err_in;
         older_err_ff <= older_err_in;
         drive_ff     <= drive_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_err_ff    <= s1_err_in;
      s1_sel_ff    <= s1_sel_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

### bench/tb_gain_scheduled_incremental_pid.sv
// Self-checking testbench for gain_scheduled_incremental_pid: directed table, then random phases.
module tb_gain_scheduled_incremental_pid;
   import gsip_pkg::*;

   // Run limits and register indexes not covered by the package
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 150;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   // Register setups used by the directed table
   typedef enum logic [2:0] {
      KEEP, SETUP_BASE, SETUP_CROSSED, SETUP_NARROW, SETUP_FLAT
   } setup_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic               no_row;
   } drive_result_type;

   typedef struct {
      setup_type                 setup;
      logic signed [SPEED_W-1:0] target;
      logic signed [SPEED_W-1:0] measured;
      bit                        pinned;
      logic [DRIVE_W-1:0]        want_drive;
      logic                      want_no_row;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [SPEED_W-1:0]   req_target_speed = '0;
   logic signed [SPEED_W-1:0]   req_measured_speed = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [DRIVE_W-1:0]          rsp_drive_level;
   logic                        rsp_no_gain_row;

   // Predictor copy of the registers and the loop state
   gain_row_type                sched_rows [ROW_REGS] = '{default: '0};
   logic [DRIVE_W-1:0]          clamp_lo = MIN_DRIVE_RST;
   logic [DRIVE_W-1:0]          clamp_hi = MAX_DRIVE_RST;
   int                          prev_err = 0;
   int                          prev2_err = 0;
   logic [DRIVE_W-1:0]          drive_acc = '0;

   drive_result_type            pending_drive_q [$];
   int                          send_idle_pct = 0;
   int                          rsp_stall_pct = 0;
   int                          mismatches = 0;
   int                          cycle_count = 0;
   int                          items_sent = 0;
   int                          drives_seen = 0;
   int                          no_row_seen = 0;
   int                          setups_done = 0;

   localparam logic signed [SPEED_W-1:0] SPEED_CORNERS [6] =
      '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};

   // Directed rows: pinned results follow from reset state, extremes or empty schedules
   stim_row_type directed_rows [22] = '{
      '{KEEP,          0,      0,      1'b1, 16'd0,     1'b1},
      '{KEEP,          -32768, 32767,  1'b1, 16'd0,     1'b1},
      '{KEEP,          32767,  -32768, 1'b1, 16'd0,     1'b1},
      '{SETUP_BASE,    10,     -10,    1'b1, 16'd5000,  1'b0},
      '{KEEP,          100,    90,     1'b0, 16'd0,     1'b0},
      '{KEEP,          -32768, 0,      1'b1, 16'd65535, 1'b0},
      '{KEEP,          0,      -32768, 1'b1, 16'd5000,  1'b0},
      '{KEEP,          32767,  0,      1'b0, 16'd0,     1'b0},
      '{KEEP,          -1,     1,      1'b0, 16'd0,     1'b0},
      '{KEEP,          1200,   100,    1'b0, 16'd0,     1'b0},
      '{KEEP,          300,    -100,   1'b0, 16'd0,     1'b0},
      '{SETUP_CROSSED, 500,    400,    1'b0, 16'd0,     1'b0},
      '{KEEP,          400,    500,    1'b0, 16'd0,     1'b0},
      '{KEEP,          5,      5,      1'b0, 16'd0,     1'b0},
      '{SETUP_NARROW,  3,      0,      1'b0, 16'd0,     1'b0},
      '{KEEP,          -32768, -32768, 1'b0, 16'd0,     1'b0},
      '{KEEP,          2,      0,      1'b0, 16'd0,     1'b0},
      '{KEEP,          0,      2,      1'b0, 16'd0,     1'b0},
      '{KEEP,          32767,  32767,  1'b0, 16'd0,     1'b0},
      '{KEEP,          -20000, 5,      1'b0, 16'd0,     1'b0},
      '{SETUP_FLAT,    1234,   -4321,  1'b0, 16'd0,     1'b0},
      '{KEEP,          -32767, 32767,  1'b0, 16'd0,     1'b0}
   };

   gain_scheduled_incremental_pid dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_speed   (req_target_speed),
      .req_measured_speed (req_measured_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_no_gain_row    (rsp_no_gain_row)
   );

   always #10 clock = ~clock;

   // Pack one schedule row: threshold low, then kp, ki, kd
   function automatic gain_row_type pack_row(input int thr, input int kp, input int ki,
                                             input int kd);
      return {GAIN_W'(kd), GAIN_W'(ki), GAIN_W'(kp), GAIN_W'(thr)};
   endfunction

   // Advance the loop by one speed pair and return the drive it produces
   function automatic drive_result_type pid_step(input logic signed [SPEED_W-1:0] target,
                                                 input logic signed [SPEED_W-1:0] measured);
      int               tmag;
      int               mmag;
      int               err;
      int               err_mag;
      int               row;
      longint           kp;
      longint           ki;
      longint           kd;
      longint           acc;
      longint           delta;
      longint           sum;
      drive_result_type res;
      tmag = (target < 0) ? -int'(target) : int'(target);
      mmag = (measured < 0) ? -int'(measured) : int'(measured);
      err = tmag - mmag;
      err_mag = (err < 0) ? -err : err;
      row = -1;
      for (int i = 0; i < SEL_ROWS; i++) begin
         if (row < 0 && int'(sched_rows[i][15:0]) > err_mag) row = i;
      end
      if (row < 0) begin
         res.drive = drive_acc;
         res.no_row = 1'b1;
         return res;
      end
      kp = longint'(sched_rows[row][31:16]);
      ki = longint'(sched_rows[row][47:32]);
      kd = longint'(sched_rows[row][63:48]);
      acc = kp * longint'(err - prev_err) + ki * longint'(err)
          + kd * (longint'(err) - 2 * longint'(prev_err) + longint'(prev2_err));
      // truncate toward zero
      delta = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
      sum = longint'(drive_acc) + delta;
      if (sum > longint'(clamp_hi)) sum = longint'(clamp_hi);
      else if (sum < longint'(clamp_lo)) sum = longint'(clamp_lo);
      drive_acc = sum[DRIVE_W-1:0];
      prev2_err = prev_err;
      prev_err = err;
      res.drive = drive_acc;
      res.no_row = 1'b0;
      return res;
   endfunction

   // Present one speed pair, hold it until the transfer, then queue its drive
   task automatic send_pair(input logic signed [SPEED_W-1:0] target,
                            input logic signed [SPEED_W-1:0] measured,
                            input bit pinned, input drive_result_type pinned_res);
      drive_result_type predicted;
      req_valid <= 1'b1;
      req_target_speed <= target;
      req_measured_speed <= measured;
      do @(posedge clock); while (!req_ready);
      predicted = pid_step(target, measured);
      pending_drive_q.push_back(pinned ? pinned_res : predicted);
      items_sent++;
   endtask

   // Drop valid and hold until every queued drive has come back
   task automatic drain_drives();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_drive_q.size() != 0);
   endtask

   // Write one register and mirror it in the predictor
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_MIN_DRIVE) clamp_lo = data[DRIVE_W-1:0];
      else if (idx == CSR_MAX_DRIVE) clamp_hi = data[DRIVE_W-1:0];
      else if (idx < CSR_ROW0 + ROW_REGS) sched_rows[ROW_IDX_W'(idx - CSR_ROW0)] = data;
   endtask

   // Load one of the directed register setups
   task automatic apply_setup(input setup_type setup);
      drain_drives();
      case (setup)
         SETUP_BASE: begin
            csr_put(CSR_IDX_W'(CSR_ROW0 + 0), pack_row(16, 64, 0, 0));
            csr_put(CSR_IDX_W'(CSR_ROW0 + 1), pack_row(1024, 64, 32, 16));
            csr_put(CSR_IDX_W'(CSR_ROW0 + 2), pack_row(32768, 256, 8, 512));
            csr_put(CSR_IDX_W'(CSR_ROW0 + 3), pack_row(65535, 65535, 65535, 65535));
            csr_put(CSR_MIN_DRIVE, 64'd5000);
            csr_put(CSR_MAX_DRIVE, 64'd65535);
         end
         SETUP_CROSSED: begin
            csr_put(CSR_MIN_DRIVE, 64'd65535);
            csr_put(CSR_MAX_DRIVE, 64'd0);
         end
         SETUP_NARROW: begin
            // thresholds too small for most errors; spare indexes must be ignored
            csr_put(CSR_IDX_W'(CSR_ROW0 + 0), pack_row(3, 128, 64, 1));
            csr_put(CSR_IDX_W'(CSR_ROW0 + 1), pack_row(2, 1, 2, 3));
            csr_put(CSR_IDX_W'(CSR_ROW0 + 2), pack_row(1, 7, 7, 7));
            csr_put(CSR_IDX_W'(CSR_ROW0 + 3), pack_row(0, 65535, 65535, 65535));
            csr_put(CSR_MIN_DRIVE, 64'd0);
            csr_put(CSR_MAX_DRIVE, 64'd32768);
            csr_put(CSR_SPARE_A, '1);
            csr_put(CSR_SPARE_B, 64'h0123_4567_89AB_CDEF);
         end
         SETUP_FLAT: begin
            csr_put(CSR_IDX_W'(CSR_ROW0 + 0), pack_row(65535, 0, 0, 0));
            csr_put(CSR_MIN_DRIVE, 64'd0);
            csr_put(CSR_MAX_DRIVE, 64'd65535);
         end
         default: ;
      endcase
      csr_we <= 1'b0;
      setups_done++;
   endtask

   // Load a random schedule; clamp_mode picks full, ordinary, crossed or pinned clamps
   task automatic random_setup(input int clamp_mode);
      int thr [ROW_REGS];
      int lo;
      int hi;
      drain_drives();
      thr[0] = $urandom_range(1, 100);
      for (int i = 1; i < ROW_REGS; i++) begin
         thr[i] = thr[i-1] + $urandom_range(0, 4000 * i);
         if (thr[i] > 65535) thr[i] = 65535;
      end
      if ($urandom_range(1)) thr[ROW_REGS-1] = 65535;
      if ($urandom_range(4) == 0) begin
         foreach (thr[i]) thr[i] = $urandom_range(0, 65535);
      end
      for (int i = 0; i < ROW_REGS; i++) begin
         if ($urandom_range(7) == 0)
            csr_put(CSR_IDX_W'(CSR_ROW0 + i), {$urandom, $urandom});
         else
            csr_put(CSR_IDX_W'(CSR_ROW0 + i), pack_row(thr[i], $urandom_range(0, 160),
                                           $urandom_range(0, 160), $urandom_range(0, 160)));
      end
      case (clamp_mode)
         0: begin
            lo = 0;
            hi = 65535;
         end
         1: begin
            lo = $urandom_range(0, 30000);
            hi = lo + $urandom_range(1000, 35535);
         end
         2: begin
            lo = $urandom_range(30000, 65535);
            hi = $urandom_range(0, 29999);
         end
         default: begin
            lo = $urandom_range(0, 65535);
            hi = lo;
         end
      endcase
      csr_put(CSR_MIN_DRIVE, CSR_DATA_W'(lo));
      csr_put(CSR_MAX_DRIVE, CSR_DATA_W'(hi));
      csr_we <= 1'b0;
      setups_done++;
   endtask

   // Mostly nearby speed pairs that walk the schedule, some noise and corners
   task automatic send_random_pair();
      int                        pick;
      int                        t;
      int                        m;
      int                        delta;
      logic signed [SPEED_W-1:0] ts;
      logic signed [SPEED_W-1:0] ms;
      pick = $urandom_range(99);
      if (pick < 70) begin
         t = ($urandom_range(3) == 0) ? $urandom_range(0, 32768) : $urandom_range(0, 3000);
         delta = $urandom_range(0, $urandom_range(1) ? 40 : 1500);
         m = $urandom_range(1) ? t + delta : t - delta;
         if (m < 0) m = -m;
         if (m > 32768) m = 32768;
         ts = (t == 32768 || $urandom_range(1)) ? SPEED_W'(-t) : SPEED_W'(t);
         ms = (m == 32768 || $urandom_range(1)) ? SPEED_W'(-m) : SPEED_W'(m);
      end else if (pick < 88) begin
         ts = SPEED_W'($urandom);
         ms = SPEED_W'($urandom);
      end else begin
         ts = SPEED_CORNERS[$urandom_range(0, 5)];
         ms = SPEED_CORNERS[$urandom_range(0, 5)];
      end
      send_pair(ts, ms, 1'b0, '0);
   endtask

   // Stall the result channel at the phase's rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check each drive transfer against the oldest queued expectation
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive_q.size() == 0) begin
            $error("unexpected drive transfer: drive_level %0d, no_gain_row %0d",
                   rsp_drive_level, rsp_no_gain_row);
            mismatches++;
         end else begin
            want = pending_drive_q.pop_front();
            drives_seen++;
            if (rsp_no_gain_row === 1'b1) no_row_seen++;
            if (rsp_drive_level !== want.drive) begin
               $error("drive_level: expected %0d, got %0d", want.drive, rsp_drive_level);
               mismatches++;
            end
            if (rsp_no_gain_row !== want.no_row) begin
               $error("no_gain_row: expected %0d, got %0d", want.no_row, rsp_no_gain_row);
               mismatches++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("gain_scheduled_incremental_pid test failed");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then four idling phases of random pairs
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].setup != KEEP) apply_setup(directed_rows[i].setup);
         send_pair(directed_rows[i].target, directed_rows[i].measured, directed_rows[i].pinned,
                   '{drive: directed_rows[i].want_drive, no_row: directed_rows[i].want_no_row});
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         random_setup(phase);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // halfway: let the pipe run dry, then change the schedule
            if (k == PHASE_ITEMS / 2) random_setup(phase % 2);
            send_random_pair();
            if ($urandom_range(99) < send_idle_pct) begin
               req_valid <= 1'b0;
               do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
            end
         end
      end

      drain_drives();
      repeat (5) @(posedge clock);
      if (pending_drive_q.size() != 0) begin
         $error("%0d drive results never arrived", pending_drive_q.size());
         mismatches++;
      end
      $display("Covered %0d speed pairs and %0d drive results (%0d with no gain row)",
               items_sent, drives_seen, no_row_seen);
      $display("across %0d register setups and four idling phases.", setups_done);
      if (mismatches == 0)
         $display("gain_scheduled_incremental_pid test passed");
      else
         $display("gain_scheduled_incremental_pid test failed");
      $finish;
   end

endmodule

### sim.f
src/gsip_pkg.sv
src/gsip_row_select.sv
src/gain_scheduled_incremental_pid.sv
bench/tb_gain_scheduled_incremental_pid.sv
